// ===== src/iocnt_pkg.sv =====
`timescale 1ns / 1ps
// Interval overlap counter package: sizes, command codes and the
// command/status structs shared by the controller and the datapath.
package iocnt_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int CHROM_BITS  = 8;
    localparam int POS_BITS    = 32;

    localparam int KEY_BITS   = CHROM_BITS + POS_BITS;
    localparam int ADDR_BITS  = $clog2(STORE_DEPTH);
    localparam int CNT_BITS   = $clog2(STORE_DEPTH + 1);
    localparam int CMD_BITS   = 2;
    localparam int CHROM_W    = 8;
    localparam int COORD_W    = 32;
    localparam int OCOUNT_W   = 11;

    localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

    localparam logic STATUS_ANSWER  = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    typedef struct packed {
        logic search_init;
        logic search_cmp;
        logic shift_init;
        logic shift_step;
        logic insert;
    } t_lane_cmd;

    typedef struct packed {
        logic search_done;
        logic shift_done;
    } t_lane_sts;

    typedef struct packed {
        logic      capture;
        t_lane_cmd lane;
        logic      count_clear;
        logic      out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_load;
        logic is_query;
        logic is_clear;
        logic empty;
        logic full;
        logic out_free;
        logic search_done;
        logic shift_done;
    } t_dp_sts;

endpackage

// ===== src/iocnt_lane.sv =====
`timescale 1ns / 1ps
// One sorted key store: memory, binary search bounds and insertion shifter.
// Depends on iocnt_pkg.
module iocnt_lane (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  iocnt_pkg::t_lane_cmd            i_cmd,
    input  logic [iocnt_pkg::KEY_BITS-1:0]  i_key,
    input  logic                            i_strict,
    input  logic [iocnt_pkg::CNT_BITS-1:0]  i_count,
    output logic [iocnt_pkg::CNT_BITS-1:0]  o_pos,
    output iocnt_pkg::t_lane_sts            o_sts
);

    logic [iocnt_pkg::KEY_BITS-1:0]  mem [iocnt_pkg::STORE_DEPTH];
    logic [iocnt_pkg::KEY_BITS-1:0]  r_rdata;
    logic [iocnt_pkg::CNT_BITS-1:0]  r_lo, n_lo, r_hi, n_hi, r_ptr, n_ptr;
    logic                            r_wpend, n_wpend;
    logic [iocnt_pkg::ADDR_BITS-1:0] r_waddr, n_waddr;
    logic [iocnt_pkg::CNT_BITS-1:0]  mid, ptr_dec;
    logic [iocnt_pkg::ADDR_BITS-1:0] raddr, waddr;
    logic [iocnt_pkg::KEY_BITS-1:0]  wdata;
    logic                            we, go_right;

    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign ptr_dec  = r_ptr - 1'b1;
    assign raddr    = i_cmd.shift_step ? ptr_dec[iocnt_pkg::ADDR_BITS-1:0]
                                       : mid[iocnt_pkg::ADDR_BITS-1:0];
    assign we       = r_wpend | i_cmd.insert;
    assign waddr    = i_cmd.insert ? r_lo[iocnt_pkg::ADDR_BITS-1:0] : r_waddr;
    assign wdata    = i_cmd.insert ? i_key : r_rdata;
    assign go_right = i_strict ? (r_rdata < i_key) : (r_rdata <= i_key);

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_comb begin
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_ptr   = r_ptr;
        n_wpend = 1'b0;
        n_waddr = r_waddr;
        if (i_cmd.search_init) begin
            n_lo = '0;
            n_hi = i_count;
        end
        if (i_cmd.search_cmp && (r_lo < r_hi)) begin
            if (go_right) begin
                n_lo = mid + 1'b1;
            end else begin
                n_hi = mid;
            end
        end
        if (i_cmd.shift_init) begin
            n_ptr = i_count;
        end
        if (i_cmd.shift_step && (r_ptr > r_lo)) begin
            n_ptr   = ptr_dec;
            n_wpend = 1'b1;
            n_waddr = r_ptr[iocnt_pkg::ADDR_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo    <= '0;
            r_hi    <= '0;
            r_ptr   <= '0;
            r_wpend <= 1'b0;
        end else begin
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_ptr   <= n_ptr;
            r_wpend <= n_wpend;
        end
        r_waddr <= n_waddr;
    end

    assign o_pos             = r_lo;
    assign o_sts.search_done = (r_lo >= r_hi);
    assign o_sts.shift_done  = (r_ptr == r_lo) && !r_wpend;

endmodule

// ===== src/iocnt_dp.sv =====
`timescale 1ns / 1ps
// Datapath: transaction capture, key forming, both key stores, entry count
// and the result register. Depends on iocnt_pkg and iocnt_lane.
module iocnt_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  iocnt_pkg::t_dp_cmd                i_cmd,
    output iocnt_pkg::t_dp_sts                o_sts,
    input  logic [iocnt_pkg::CMD_BITS-1:0]    i_command,
    input  logic [iocnt_pkg::CHROM_W-1:0]     i_chrom_id,
    input  logic [iocnt_pkg::COORD_W-1:0]     i_interval_start,
    input  logic [iocnt_pkg::COORD_W-1:0]     i_interval_end,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [iocnt_pkg::OCOUNT_W-1:0]    o_overlap_count,
    output logic                              o_status
);

    logic [iocnt_pkg::CMD_BITS-1:0]   r_cmd;
    logic [iocnt_pkg::CHROM_BITS-1:0] r_chrom;
    logic [iocnt_pkg::POS_BITS-1:0]   r_s, r_e;
    logic [iocnt_pkg::CNT_BITS-1:0]   r_count, n_count;
    logic                             r_out_valid, n_out_valid;
    logic [iocnt_pkg::OCOUNT_W-1:0]   r_ocount, n_ocount;
    logic                             r_ostatus, n_ostatus;
    logic                             is_query;
    logic [iocnt_pkg::KEY_BITS-1:0]   start_key, end_key;
    logic [iocnt_pkg::CNT_BITS-1:0]   start_pos, end_pos, diff;
    iocnt_pkg::t_lane_sts             start_sts, end_sts;

    assign is_query  = (r_cmd == iocnt_pkg::CMD_QUERY);
    assign start_key = {r_chrom, is_query ? r_e : r_s};
    assign end_key   = {r_chrom, is_query ? r_s : r_e};
    assign diff      = (start_pos >= end_pos) ? (start_pos - end_pos) : '0;

    iocnt_lane u_start_lane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd.lane),
        .i_key    (start_key),
        .i_strict (is_query),
        .i_count  (r_count),
        .o_pos    (start_pos),
        .o_sts    (start_sts)
    );

    iocnt_lane u_end_lane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd.lane),
        .i_key    (end_key),
        .i_strict (1'b0),
        .i_count  (r_count),
        .o_pos    (end_pos),
        .o_sts    (end_sts)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= i_command;
            r_chrom <= i_chrom_id[iocnt_pkg::CHROM_BITS-1:0];
            r_s     <= i_interval_start[iocnt_pkg::POS_BITS-1:0];
            r_e     <= i_interval_end[iocnt_pkg::POS_BITS-1:0];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.count_clear) begin
            n_count = '0;
        end else if (i_cmd.lane.insert) begin
            n_count = r_count + 1'b1;
        end
        n_out_valid = r_out_valid && i_out_stall;
        n_ocount    = r_ocount;
        n_ostatus   = r_ostatus;
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
            n_ocount    = is_query ? iocnt_pkg::OCOUNT_W'(diff) : '0;
            n_ostatus   = is_query ? iocnt_pkg::STATUS_ANSWER : iocnt_pkg::STATUS_DROPPED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_ocount  <= n_ocount;
        r_ostatus <= n_ostatus;
    end

    assign o_sts.is_load     = (r_cmd == iocnt_pkg::CMD_LOAD);
    assign o_sts.is_query    = is_query;
    assign o_sts.is_clear    = (r_cmd == iocnt_pkg::CMD_CLEAR);
    assign o_sts.empty       = (r_s >= r_e);
    assign o_sts.full        = (r_count == iocnt_pkg::CNT_BITS'(iocnt_pkg::STORE_DEPTH));
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;
    assign o_sts.search_done = start_sts.search_done && end_sts.search_done;
    assign o_sts.shift_done  = start_sts.shift_done && end_sts.shift_done;

    assign o_out_valid     = r_out_valid;
    assign o_overlap_count = r_ocount;
    assign o_status        = r_ostatus;

endmodule

// ===== src/iocnt_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: decode, search, shift, insert and respond.
// Depends on iocnt_pkg.
module iocnt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  iocnt_pkg::t_dp_sts i_sts,
    output iocnt_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_SRD   = 3'd2;
    localparam logic [2:0] S_SCMP  = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_INS   = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_IDLE;
                if (i_sts.is_clear) begin
                    o_cmd.count_clear = 1'b1;
                end else if (i_sts.is_load && !i_sts.empty) begin
                    if (i_sts.full) begin
                        n_state = S_RESP;
                    end else begin
                        o_cmd.lane.search_init = 1'b1;
                        n_state                = S_SRD;
                    end
                end else if (i_sts.is_query && !i_sts.empty) begin
                    o_cmd.lane.search_init = 1'b1;
                    n_state                = S_SRD;
                end
            end
            S_SRD: begin
                if (!i_sts.search_done) begin
                    n_state = S_SCMP;
                end else if (i_sts.is_query) begin
                    n_state = S_RESP;
                end else begin
                    o_cmd.lane.shift_init = 1'b1;
                    n_state               = S_SHIFT;
                end
            end
            S_SCMP: begin
                o_cmd.lane.search_cmp = 1'b1;
                n_state               = S_SRD;
            end
            S_SHIFT: begin
                o_cmd.lane.shift_step = 1'b1;
                if (i_sts.shift_done) begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                o_cmd.lane.insert = 1'b1;
                n_state           = S_IDLE;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== src/interval_overlap_counter.sv =====
`timescale 1ns / 1ps
// Interval overlap counter top level. Depends on iocnt_pkg, iocnt_ctrl, iocnt_dp.
// Query: two binary searches over the n stored intervals run in parallel, with one registered
// memory read per search step.
// Load: the same searches, then the entries above the insertion point move up in both stores,
// then the new key is inserted. Clear, empty, unknown and refused load transactions skip the search.
// One transaction at a time; a waiting result holds only the next result. Sync reset empties.
module interval_overlap_counter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [iocnt_pkg::CMD_BITS-1:0]  i_command,
    input  logic [iocnt_pkg::CHROM_W-1:0]   i_chrom_id,
    input  logic [iocnt_pkg::COORD_W-1:0]   i_interval_start,
    input  logic [iocnt_pkg::COORD_W-1:0]   i_interval_end,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [iocnt_pkg::OCOUNT_W-1:0]  o_overlap_count,
    output logic                            o_status
);

    iocnt_pkg::t_dp_cmd dp_cmd;
    iocnt_pkg::t_dp_sts dp_sts;

    iocnt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    iocnt_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_sts            (dp_sts),
        .i_command        (i_command),
        .i_chrom_id       (i_chrom_id),
        .i_interval_start (i_interval_start),
        .i_interval_end   (i_interval_end),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_overlap_count  (o_overlap_count),
        .o_status         (o_status)
    );

endmodule
